@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by recency_retention_window.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, ignored while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the cycle after the antecedent holds.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rrw_pkg.sv @@
// ----------------------------------------------------------------------------
// rrw_pkg
// Widths, codes and reset values of the recency retention window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrw_pkg;

    localparam int FP_W          = 64;
    localparam int CAP_W         = 7;
    localparam int OCC_W         = 7;
    localparam int DEPTH_DEFAULT = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Request actions.
    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

endpackage

@@ hdl/recency_retention_window.sv @@
// A query scans S entries and a record also moves M entries to close the gap, both over the
// one shared RAM port pair; S+M never exceeds the occupancy N.
// One request is handled at a time; the next is accepted once the result is registered.
// Reset (synchronous, active low) empties the window, sets capacity 64, keeps storage as is.
// ----------------------------------------------------------------------------
// recency_retention_window
// Ordered window of distinct fingerprints with move-to-newest and trimming.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module recency_retention_window
    import rrw_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Configuration write.
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    // Request channel.
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_action,
    input  logic [FP_W-1:0]  i_fingerprint,
    // Result channel.
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_was_present,
    output logic [OCC_W-1:0] o_occupancy
);

    // The window lives in a ring buffer: r_head is the physical slot of the
    // oldest entry and r_count the number of entries. Logical position k maps
    // to slot (r_head + k) mod WINDOW_DEPTH. Dropping oldest entries only moves
    // the head; removing a middle entry copies every newer entry down by one.
    // Only entries below the occupancy are ever read, so the storage is never
    // cleared.
    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int XW = ((AW > OCC_W) ? AW : OCC_W) + 1;
    localparam logic [XW-1:0] DEPTH_X = XW'(WINDOW_DEPTH);
    localparam logic [XW-1:0] ONE_X   = XW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,      // issue a scan read
        S_CMP,     // compare the read entry with the request fingerprint
        S_MV_RD,   // read the entry just above the gap
        S_MV_WR,   // write it one place down
        S_APPEND,  // make room when storage is full
        S_WRITE,   // store the fingerprint as newest
        S_TRIM     // drop oldest entries above capacity
    } t_state;

    // Instead of an S_DONE state, a separate phase marks a finished request: see t_state above.
    typedef enum logic {
        P_BUSY,
        P_DONE
    } t_phase;

    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic               r_action, n_action;
    logic [FP_W-1:0]    r_fp, n_fp;
    logic [AW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_head, n_head;
    // Wide enough to hold the full storage depth for any depth.
    logic [XW-1:0]      r_count, n_count;
    logic               r_found, n_found;
    logic [CAP_W-1:0]   r_cap, n_cap;
    logic               r_out_valid, n_out_valid;
    logic               r_was_present, n_was_present;
    logic [OCC_W-1:0]   r_occupancy, n_occupancy;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [FP_W-1:0]    ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [FP_W-1:0]    ram_rdata;

    logic [XW-1:0]      idx_x;
    logic [XW-1:0]      cnt_x;
    logic [XW-1:0]      ecap_x;
    logic               match;

    // Physical slot of logical offset off; base + off stays below twice the depth.
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] base,
                                             input logic [XW-1:0] off);
        logic [XW-1:0] s;
        s = XW'(base) + off;
        if (s >= DEPTH_X) begin
            s = s - DEPTH_X;
        end
        return s[AW-1:0];
    endfunction

    rrw_entry_ram #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign idx_x  = XW'(r_idx);
    assign cnt_x  = r_count;
    // A capacity above the storage depth saturates to the depth.
    assign ecap_x = (XW'(r_cap) > DEPTH_X) ? DEPTH_X : XW'(r_cap);
    // The one comparator of the scan.
    assign match  = (ram_rdata == r_fp);

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_action      = r_action;
        n_fp          = r_fp;
        n_idx         = r_idx;
        n_head        = r_head;
        n_count       = r_count;
        n_found       = r_found;
        n_cap         = i_cfg_we ? i_cfg_wdata : r_cap;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_was_present = r_was_present;
        n_occupancy   = r_occupancy;
        ram_we        = 1'b0;
        ram_waddr     = f_phys(r_head, idx_x);
        ram_wdata     = ram_rdata;
        ram_raddr     = f_phys(r_head, idx_x);

        if (r_phase == P_DONE) begin
            // Hand the result over as soon as the output register is free.
            if (!r_out_valid || i_out_ready) begin
                n_out_valid   = 1'b1;
                n_was_present = r_found;
                n_occupancy   = r_count[OCC_W-1:0];
                n_phase       = P_BUSY;
                n_state       = S_IDLE;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        n_action = i_action;
                        n_fp     = i_fingerprint;
                        n_idx    = '0;
                        n_found  = 1'b0;
                        if (r_count == '0) begin
                            if (i_action == ACT_QUERY) begin
                                n_phase = P_DONE;
                            end else begin
                                n_state = S_APPEND;
                            end
                        end else begin
                            n_state = S_RD;
                        end
                    end
                end
                S_RD: begin
                    n_state = S_CMP;
                end
                S_CMP: begin
                    if (match) begin
                        n_found = 1'b1;
                        if (r_action == ACT_QUERY) begin
                            n_phase = P_DONE;
                        end else begin
                            // Remove the match; newer entries slide down one place.
                            n_count = r_count - 1'b1;
                            if (idx_x + ONE_X < cnt_x) begin
                                n_state = S_MV_RD;
                            end else begin
                                n_state = S_APPEND;
                            end
                        end
                    end else if (idx_x + ONE_X == cnt_x) begin
                        if (r_action == ACT_QUERY) begin
                            n_phase = P_DONE;
                        end else begin
                            n_state = S_APPEND;
                        end
                    end else begin
                        n_idx   = AW'(idx_x + ONE_X);
                        n_state = S_RD;
                    end
                end
                S_MV_RD: begin
                    ram_raddr = f_phys(r_head, idx_x + ONE_X);
                    n_state   = S_MV_WR;
                end
                S_MV_WR: begin
                    ram_we    = 1'b1;
                    ram_waddr = f_phys(r_head, idx_x);
                    ram_wdata = ram_rdata;
                    n_idx     = AW'(idx_x + ONE_X);
                    // r_count already holds the count after the removal.
                    if (idx_x + ONE_X < cnt_x) begin
                        n_state = S_MV_RD;
                    end else begin
                        n_state = S_APPEND;
                    end
                end
                S_APPEND: begin
                    // Full storage loses its oldest entry before the append.
                    if (cnt_x >= DEPTH_X) begin
                        n_head  = f_phys(r_head, ONE_X);
                        n_count = r_count - 1'b1;
                    end
                    n_state = S_WRITE;
                end
                S_WRITE: begin
                    ram_we    = 1'b1;
                    ram_waddr = f_phys(r_head, cnt_x);
                    ram_wdata = r_fp;
                    n_count   = r_count + 1'b1;
                    n_state   = S_TRIM;
                end
                S_TRIM: begin
                    if (cnt_x > ecap_x) begin
                        n_head  = f_phys(r_head, cnt_x - ecap_x);
                        n_count = ecap_x;
                    end
                    n_phase = P_DONE;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= P_BUSY;
            r_head      <= '0;
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_head      <= n_head;
            r_count     <= n_count;
            r_cap       <= n_cap;
            r_out_valid <= n_out_valid;
        end
        r_action      <= n_action;
        r_fp          <= n_fp;
        r_idx         <= n_idx;
        r_found       <= n_found;
        r_was_present <= n_was_present;
        r_occupancy   <= n_occupancy;
    end

    // A new request is taken only while the sequencer rests.
    assign o_in_ready    = (r_state == S_IDLE) && (r_phase == P_BUSY);
    assign o_out_valid   = r_out_valid;
    assign o_was_present = r_was_present;
    assign o_occupancy   = r_occupancy;

    // The window never holds more entries than the storage has slots.
    `ASSERT_CLK(a_count_in_range, i_clk, i_rst_n, r_count <= DEPTH_X,
        "entry count exceeds storage depth")
    // An accepted request keeps the block busy for at least the next cycle.
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready,
        "request accepted while a previous one is still in flight")
    // A result appears only when the sequencer has finished a request.
    `ASSERT_NEXT(a_result_from_done, i_clk, i_rst_n, !o_out_valid && !(r_phase == P_DONE),
        !o_out_valid, "result raised without a finished request")

endmodule

@@ hdl/rrw_entry_ram.sv @@
// ----------------------------------------------------------------------------
// rrw_entry_ram
// Fingerprint storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrw_entry_ram
    import rrw_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  logic [FP_W-1:0] i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output logic [FP_W-1:0] o_rdata
);

    logic [FP_W-1:0] r_mem [DEPTH];
    logic [FP_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
